/* sv/icer_pkg.sv */
// Package for the ICMP echo responder: sizes, codes, the stage record type
// and the Internet checksum add. No dependencies.
package icer_pkg;

    localparam int MAX_LEN = 2048;
    localparam int ADDR_W  = $clog2(MAX_LEN);

    localparam logic [16:0] MAX_LEN_W = 17'(MAX_LEN);
    localparam logic [15:0] MIN_LEN   = 16'd8;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] SUM_GOOD  = 16'hFFFF;

    // input item kinds (tuser)
    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    // result kinds (tuser)
    localparam logic RES_VERDICT = 1'b0;
    localparam logic RES_BYTE    = 1'b1;

    // verdict codes
    localparam logic [2:0] V_ACCEPT   = 3'd0;
    localparam logic [2:0] V_SHORT    = 3'd1;
    localparam logic [2:0] V_NOT_ECHO = 3'd2;
    localparam logic [2:0] V_BAD_SUM  = 3'd3;
    localparam logic [2:0] V_TOO_LONG = 3'd4;

    // ICMP header values
    localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_CODE_ECHO  = 8'd0;

    // one result in flight between the state stage and the output register
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  verdict;
        logic [7:0]  byte_val;     // used when use_mem is low
        logic        use_mem;      // byte comes from the store read port
        logic        reply_last;
        logic [31:0] dest_addr;
        logic [15:0] reply_length;
    } t_stage;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

/* sv/icer_store.sv */
// Message byte store: one write port, one registered read port.
// Depends on icer_pkg for depth and address width.
module icer_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [icer_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic                        i_re,
    input  logic [icer_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] r_mem [icer_pkg::MAX_LEN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/icer_core.sv */
// Message state stage: counters, checksums, verdict and reply sequencing,
// feeding one staged result. Depends on icer_pkg and icer_store.
module icer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic [31:0]          i_src_addr,
    output logic                 o_stage_valid,
    output icer_pkg::t_stage     o_stage,
    output logic [7:0]           o_rd_data,
    input  logic                 i_stage_take
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_full_sum, n_full_sum;
    logic [15:0] r_reply_sum, n_reply_sum;
    logic [31:0] r_peer, n_peer;
    logic        r_pending, n_pending;
    logic [15:0] r_idx, n_idx;
    logic        r_ovr, n_ovr;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic        r_s1_valid, n_s1_valid;
    icer_pkg::t_stage r_s1, n_s1;

    logic        accept;
    logic [15:0] word, rword;
    logic [15:0] csum;
    logic [16:0] idx_next;
    logic        fin;
    logic        wr_en, rd_en;
    logic [2:0]  verdict;
    logic [15:0] count_upd;
    logic        ovr_upd;
    logic [15:0] full_upd, reply_upd;
    logic [7:0]  type_upd, code_upd;

    assign o_ready  = !r_s1_valid || i_stage_take;
    assign accept   = i_valid && o_ready;

    assign word     = r_count[0] ? {8'd0, i_data_byte} : {i_data_byte, 8'd0};
    assign rword    = (r_count == 16'd0 || r_count == 16'd2 || r_count == 16'd3) ? 16'd0 : word;
    assign csum     = ~r_reply_sum;
    assign idx_next = {1'b0, r_idx} + 17'd1;
    assign fin      = idx_next >= {1'b0, r_count};

    // message state after taking this byte, before any clear
    assign count_upd = (r_count != icer_pkg::COUNT_MAX) ? r_count + 16'd1 : r_count;
    assign ovr_upd   = r_ovr || (r_count == icer_pkg::COUNT_MAX);
    assign full_upd  = icer_pkg::sum_add(r_full_sum, word);
    assign reply_upd = icer_pkg::sum_add(r_reply_sum, rword);
    assign type_upd  = (r_count == 16'd0) ? i_data_byte : r_type;
    assign code_upd  = (r_count == 16'd1) ? i_data_byte : r_code;

    assign wr_en = accept && i_kind == icer_pkg::KIND_MSG && !r_pending
                   && {1'b0, r_count} < icer_pkg::MAX_LEN_W;
    assign rd_en = accept && i_kind == icer_pkg::KIND_PULL && r_pending
                   && {1'b0, r_idx} < icer_pkg::MAX_LEN_W;

    icer_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[icer_pkg::ADDR_W-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (rd_en),
        .i_raddr (r_idx[icer_pkg::ADDR_W-1:0]),
        .o_rdata (o_rd_data)
    );

    // verdict from the updated count, sum and header bytes
    always_comb begin
        if (count_upd < icer_pkg::MIN_LEN && !ovr_upd) begin
            verdict = icer_pkg::V_SHORT;
        end else if (type_upd != icer_pkg::ICMP_ECHO_REQ
                     || code_upd != icer_pkg::ICMP_CODE_ECHO) begin
            verdict = icer_pkg::V_NOT_ECHO;
        end else if (full_upd != icer_pkg::SUM_GOOD) begin
            verdict = icer_pkg::V_BAD_SUM;
        end else if (ovr_upd || {1'b0, count_upd} > icer_pkg::MAX_LEN_W) begin
            verdict = icer_pkg::V_TOO_LONG;
        end else begin
            verdict = icer_pkg::V_ACCEPT;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_full_sum  = r_full_sum;
        n_reply_sum = r_reply_sum;
        n_peer      = r_peer;
        n_pending   = r_pending;
        n_idx       = r_idx;
        n_ovr       = r_ovr;
        n_type      = r_type;
        n_code      = r_code;
        n_s1_valid  = r_s1_valid && !i_stage_take;
        n_s1        = r_s1;

        if (accept && i_kind == icer_pkg::KIND_MSG && !r_pending) begin
            if (r_count == 16'd0 && !r_ovr) begin
                n_peer = i_src_addr;
            end
            n_type      = type_upd;
            n_code      = code_upd;
            n_full_sum  = full_upd;
            n_reply_sum = reply_upd;
            n_count     = count_upd;
            n_ovr       = ovr_upd;

            if (i_last_byte) begin
                n_s1_valid          = 1'b1;
                n_s1.result_kind    = icer_pkg::RES_VERDICT;
                n_s1.verdict        = verdict;
                n_s1.byte_val       = 8'd0;
                n_s1.use_mem        = 1'b0;
                n_s1.reply_last     = 1'b0;
                if (verdict == icer_pkg::V_ACCEPT) begin
                    n_s1.dest_addr    = n_peer;
                    n_s1.reply_length = count_upd;
                    n_pending         = 1'b1;
                    n_idx             = 16'd0;
                end else begin
                    n_s1.dest_addr    = 32'd0;
                    n_s1.reply_length = 16'd0;
                    n_count           = 16'd0;
                    n_full_sum        = 16'd0;
                    n_reply_sum       = 16'd0;
                    n_idx             = 16'd0;
                    n_ovr             = 1'b0;
                end
            end
        end else if (accept && i_kind == icer_pkg::KIND_PULL && r_pending) begin
            n_s1_valid        = 1'b1;
            n_s1.result_kind  = icer_pkg::RES_BYTE;
            n_s1.verdict      = icer_pkg::V_ACCEPT;
            n_s1.use_mem      = 1'b0;
            n_s1.reply_last   = fin;
            n_s1.dest_addr    = r_peer;
            n_s1.reply_length = r_count;
            if (r_idx == 16'd0) begin
                n_s1.byte_val = icer_pkg::ICMP_ECHO_REPLY;
            end else if (r_idx == 16'd2) begin
                n_s1.byte_val = csum[15:8];
            end else if (r_idx == 16'd3) begin
                n_s1.byte_val = csum[7:0];
            end else begin
                n_s1.byte_val = 8'd0;
                n_s1.use_mem  = {1'b0, r_idx} < icer_pkg::MAX_LEN_W;
            end
            if (fin) begin
                n_pending   = 1'b0;
                n_count     = 16'd0;
                n_full_sum  = 16'd0;
                n_reply_sum = 16'd0;
                n_idx       = 16'd0;
                n_ovr       = 1'b0;
            end else begin
                n_idx = idx_next[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 16'd0;
            r_full_sum  <= 16'd0;
            r_reply_sum <= 16'd0;
            r_peer      <= 32'd0;
            r_pending   <= 1'b0;
            r_idx       <= 16'd0;
            r_ovr       <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_full_sum  <= n_full_sum;
            r_reply_sum <= n_reply_sum;
            r_peer      <= n_peer;
            r_pending   <= n_pending;
            r_idx       <= n_idx;
            r_ovr       <= n_ovr;
            r_s1_valid  <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_code <= n_code;
        r_s1   <= n_s1;
    end

    assign o_stage_valid = r_s1_valid;
    assign o_stage       = r_s1;

endmodule

/* sv/icmp_echo_responder_unit.sv */
// Top level of the ICMP echo responder: stream ports and output register.
// Depends on icer_pkg and icer_core.
//
// Usage:
//   Slave stream carries items. tuser = kind: 0 is a message byte, 1 pulls the
//   next reply byte. tdata = {src_addr, data_byte}; tlast marks the final
//   message byte. src_addr is captured on the first byte of a message.
//   Master stream carries results. tuser = 0 for a verdict (on the last
//   message byte), 1 for a reply byte; tlast marks the final reply byte.
//   Bytes that arrive while a reply is pending, and pulls with no reply
//   pending, are taken and dropped without a result.
// Timing:
//   One item per cycle sustained while m_axis_tready is high. A result reaches
//   the master side through the state stage (counters, checksums, store read
//   issue), then through the output register where the registered store read
//   data is merged in.
// Reset:
//   i_rst_n low clears counters, sums, pending flag and both valid stages.
//   Store contents are not cleared; only bytes of the current message are
//   ever read back.
// Stall:
//   If m_axis_tready stays low, the output register and the stage behind it
//   fill, then s_axis_tready drops; nothing is lost.
module icmp_echo_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] src_addr
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [2:0] verdict, [10:3] reply_byte,
                                        // [42:11] dest_addr, [58:43] reply_length
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast    // reply_last
);

    logic             stage_valid;
    logic             stage_take;
    icer_pkg::t_stage stage;
    logic [7:0]       rd_data;

    logic             r_out_valid, n_out_valid;
    icer_pkg::t_stage r_out, n_out;

    icer_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_last_byte   (s_axis_tlast),
        .i_src_addr    (s_axis_tdata[39:8]),
        .o_stage_valid (stage_valid),
        .o_stage       (stage),
        .o_rd_data     (rd_data),
        .i_stage_take  (stage_take)
    );

    // output register loads whenever it is empty or being drained
    assign stage_take = stage_valid && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        if (stage_take) begin
            n_out_valid = 1'b1;
            n_out       = stage;
            if (stage.use_mem) begin
                n_out.byte_val = rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tlast  = r_out.reply_last;
    assign m_axis_tdata  = {5'd0, r_out.reply_length, r_out.dest_addr,
                            r_out.byte_val, r_out.verdict};

endmodule
